// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros
// assertion macros used by the deque core
// ----------------------------------------------------------------------------
// each use samples on the rising edge of aclk and is off while aresetn is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// invariant that holds at every edge
`define BHD_ASSERT(label, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("bhd invariant violated");

// condition that must hold in the cycle after the trigger
`define BHD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bhd sequence violated");

`endif

// ----- rtl/core/bhd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhd_pkg
// request codes and controller states of the bounded handle deque
// ----------------------------------------------------------------------------
package bhd_pkg;

    // request codes carried on the input channel
    localparam logic [2:0] REQ_APPEND = 3'd0;
    localparam logic [2:0] REQ_INSERT = 3'd1;
    localparam logic [2:0] REQ_TAKE   = 3'd2;
    localparam logic [2:0] REQ_READ   = 3'd3;
    localparam logic [2:0] REQ_REMOVE = 3'd4;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RDWAIT,
        ST_SCAN,
        ST_HOLD
    } state_t;

endpackage

// ----- rtl/core/bounded_handle_deque_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_handle_deque_core
// ring buffer deque of nonzero handles in one synchronous memory, with
// append, insert at front, take from front, positional read and remove by
// value with compaction
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  --------+-----------+-----------------------------------------------------
//  s_      | in        | s_valid s_ready s_req_type s_item_value s_position
//  m_      | out       | m_valid m_ready m_ok m_item_out m_fill_count
//
//  append, insert and every refused request: result registered straight from the accept
//  take and positional read: result passes through the registered memory read and ST_RDWAIT
//  remove: a scan over every entry in ST_SCAN, one entry per cycle through the read port
//  a result that meets a full output register parks in ST_HOLD until the register frees
//  reset clears pointer, fill count and control; the memory is not cleared
// ----------------------------------------------------------------------------
module bounded_handle_deque_core
    import bhd_pkg::*;
#(
    parameter int DEPTH    = 16,
    parameter int HANDLE_W = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [2:0]                   s_req_type,
    input  logic [HANDLE_W-1:0]          s_item_value,
    input  logic [$clog2(DEPTH)-1:0]     s_position,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_ok,
    output logic [HANDLE_W-1:0]          m_item_out,
    output logic [$clog2(DEPTH+1)-1:0]   m_fill_count
);

`include "assert_macros.svh"

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W:0]   DEPTH_X  = (CNT_W + 1)'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    // ring slot of an offset from the front
    function automatic logic [PTR_W-1:0] wrap_slot(input logic [PTR_W-1:0] base,
                                                   input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + {1'b0, off};
        if (sum >= DEPTH_X) begin
            sum = sum - DEPTH_X;
        end
        return sum[PTR_W-1:0];
    endfunction

    // control state
    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   front_reg, front_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               m_valid_reg, m_valid_next;

    // working registers
    logic [HANDLE_W-1:0] handle_reg, handle_next;
    logic [CNT_W-1:0]    scan_off_reg, scan_off_next;
    logic                found_reg, found_next;
    logic                pend_ok_reg, pend_ok_next;
    logic [HANDLE_W-1:0] pend_item_reg, pend_item_next;
    logic                m_ok_reg, m_ok_next;
    logic [HANDLE_W-1:0] m_item_reg, m_item_next;
    logic [CNT_W-1:0]    m_fill_reg, m_fill_next;

    // entry memory
    logic [HANDLE_W-1:0] mem [DEPTH];
    logic                mem_we;
    logic [PTR_W-1:0]    mem_waddr;
    logic [HANDLE_W-1:0] mem_wdata;
    logic [PTR_W-1:0]    mem_raddr;
    logic [HANDLE_W-1:0] rd_data_reg;

    // request decode and result
    logic                s_accept;
    logic                out_free;
    logic                go_read;
    logic                go_scan;
    logic                scan_last;
    logic                res_valid;
    logic                res_ok;
    logic [HANDLE_W-1:0] res_item;
    logic                is_null;
    logic                is_empty;
    logic                is_full;
    logic                scan_match;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign is_null    = (s_item_value == '0);
    assign is_empty   = (count_reg == '0);
    assign is_full    = (count_reg == CNT_FULL);
    assign scan_match = (rd_data_reg == handle_reg);
    assign scan_last  = (scan_off_reg == count_reg - CNT_W'(1));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (go_read) begin
                        state_next = ST_RDWAIT;
                    end else if (go_scan) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = out_free ? ST_IDLE : ST_HOLD;
                    end
                end
            end
            ST_RDWAIT: begin
                state_next = out_free ? ST_IDLE : ST_HOLD;
            end
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = out_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath, memory access and result routing
    always_comb begin
        front_next     = front_reg;
        count_next     = count_reg;
        handle_next    = handle_reg;
        scan_off_next  = scan_off_reg;
        found_next     = found_reg;
        pend_ok_next   = pend_ok_reg;
        pend_item_next = pend_item_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_ok_next      = m_ok_reg;
        m_item_next    = m_item_reg;
        m_fill_next    = m_fill_reg;
        mem_we         = 1'b0;
        mem_waddr      = front_reg;
        mem_wdata      = s_item_value;
        mem_raddr      = front_reg;
        go_read        = 1'b0;
        go_scan        = 1'b0;
        res_valid      = 1'b0;
        res_ok         = 1'b0;
        res_item       = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    res_valid = 1'b1;
                    case (s_req_type)
                        REQ_APPEND: begin
                            if (!is_null && !is_full) begin
                                mem_we     = 1'b1;
                                mem_waddr  = wrap_slot(front_reg, count_reg);
                                count_next = count_reg + CNT_W'(1);
                                res_ok     = 1'b1;
                            end
                        end
                        REQ_INSERT: begin
                            if (!is_null && !is_full) begin
                                front_next = (front_reg == '0) ? PTR_LAST
                                                               : front_reg - PTR_W'(1);
                                mem_we     = 1'b1;
                                mem_waddr  = front_next;
                                count_next = count_reg + CNT_W'(1);
                                res_ok     = 1'b1;
                            end
                        end
                        REQ_TAKE: begin
                            if (!is_empty) begin
                                mem_raddr  = front_reg;
                                front_next = wrap_slot(front_reg, CNT_W'(1));
                                count_next = count_reg - CNT_W'(1);
                                go_read    = 1'b1;
                                res_valid  = 1'b0;
                            end
                        end
                        REQ_READ: begin
                            if (CNT_W'(s_position) < count_reg) begin
                                mem_raddr = wrap_slot(front_reg, CNT_W'(s_position));
                                go_read   = 1'b1;
                                res_valid = 1'b0;
                            end
                        end
                        REQ_REMOVE: begin
                            if (!is_null && !is_empty) begin
                                mem_raddr     = front_reg;
                                handle_next   = s_item_value;
                                scan_off_next = '0;
                                found_next    = 1'b0;
                                go_scan       = 1'b1;
                                res_valid     = 1'b0;
                            end
                        end
                        default: begin
                            res_ok = 1'b0;
                        end
                    endcase
                end
            end
            ST_RDWAIT: begin
                res_valid = 1'b1;
                res_ok    = 1'b1;
                res_item  = rd_data_reg;
            end
            ST_SCAN: begin
                // one entry per cycle; after the match each entry moves up one slot
                mem_raddr = wrap_slot(front_reg, scan_off_reg + CNT_W'(1));
                if (found_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = wrap_slot(front_reg, scan_off_reg - CNT_W'(1));
                    mem_wdata = rd_data_reg;
                end else if (scan_match) begin
                    found_next = 1'b1;
                end
                scan_off_next = scan_off_reg + CNT_W'(1);
                if (scan_last) begin
                    res_valid = 1'b1;
                    res_ok    = found_next;
                    if (found_next) begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase

        // result goes to the output register, or parks until it frees up
        if (res_valid) begin
            if (out_free) begin
                m_valid_next = 1'b1;
                m_ok_next    = res_ok;
                m_item_next  = res_item;
                m_fill_next  = count_next;
            end else begin
                pend_ok_next   = res_ok;
                pend_item_next = res_item;
            end
        end else if (state_reg == ST_HOLD && out_free) begin
            m_valid_next = 1'b1;
            m_ok_next    = pend_ok_reg;
            m_item_next  = pend_item_reg;
            m_fill_next  = count_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            front_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            front_reg   <= front_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        handle_reg    <= handle_next;
        scan_off_reg  <= scan_off_next;
        found_reg     <= found_next;
        pend_ok_reg   <= pend_ok_next;
        pend_item_reg <= pend_item_next;
        m_ok_reg      <= m_ok_next;
        m_item_reg    <= m_item_next;
        m_fill_reg    <= m_fill_next;
    end

    // entry memory, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    assign m_valid      = m_valid_reg;
    assign m_ok         = m_ok_reg;
    assign m_item_out   = m_item_reg;
    assign m_fill_count = m_fill_reg;

    // checks
    `BHD_ASSERT(a_fill_bound, count_reg <= CNT_FULL)
    `BHD_ASSERT(a_hold_out_busy, state_reg != ST_HOLD || m_valid_reg)
    `BHD_ASSERT(a_scan_in_fill, state_reg != ST_SCAN || scan_off_reg < count_reg)
    `BHD_ASSERT_NEXT(a_read_delivers, state_reg == ST_RDWAIT, m_valid_reg || state_reg == ST_HOLD)

endmodule

// ----- sim/tb_bounded_handle_deque_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_handle_deque_core
// self-checking bench for the handle deque: a clocked driver feeds requests
// from a prebuilt queue with random gaps, a clocked monitor predicts every
// accepted request against a shadow ring buffer and compares each reply
// field by field while the reply side stalls at random
// ----------------------------------------------------------------------------
module tb_bounded_handle_deque_core;
    import bhd_pkg::*;

    localparam int DEPTH      = 16;
    localparam int HANDLE_W   = 32;
    localparam int NUM_RANDOM = 2000;
    localparam int POOL_N     = 24;
    localparam int STALL_MAX  = 2000;
    localparam int DRAIN_WAIT = 40;

    typedef struct {
        logic [2:0]          kind;
        logic [HANDLE_W-1:0] handle;
        logic [3:0]          pos;
    } deque_req_t;

    typedef struct {
        logic                ok;
        logic [HANDLE_W-1:0] handle;
        logic [4:0]          fill;
    } deque_reply_t;

    typedef enum logic [1:0] {
        PH_FILL,
        PH_DRAIN,
        PH_MIX
    } phase_t;

    logic                aclk         = 1'b0;
    logic                aresetn      = 1'b0;
    logic                s_valid      = 1'b0;
    logic                s_ready;
    logic [2:0]          s_req_type   = REQ_APPEND;
    logic [HANDLE_W-1:0] s_item_value = '0;
    logic [3:0]          s_position   = '0;
    logic                m_valid;
    logic                m_ready      = 1'b0;
    logic                m_ok;
    logic [HANDLE_W-1:0] m_item_out;
    logic [4:0]          m_fill_count;

    // request stream and replies still owed by the block
    deque_req_t   req_q[$];
    deque_reply_t awaited_replies[$];

    // shadow ring buffer of the deque
    logic [HANDLE_W-1:0] shadow_slots [DEPTH];
    logic [3:0]          shadow_front = '0;
    logic [4:0]          shadow_fill  = '0;

    logic [HANDLE_W-1:0] handle_pool [POOL_N];
    logic                req_taken    = 1'b0;
    int                  send_idle    = 0;
    int                  recv_idle    = 0;
    bit                  send_burst   = 1'b0;
    bit                  recv_burst   = 1'b0;
    int                  err_count    = 0;
    int                  quiet_cycles = 0;

    bounded_handle_deque_core #(
        .DEPTH    (DEPTH),
        .HANDLE_W (HANDLE_W)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_item_value (s_item_value),
        .s_position   (s_position),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_ok         (m_ok),
        .m_item_out   (m_item_out),
        .m_fill_count (m_fill_count)
    );

    always #5 aclk = ~aclk;

    // apply one request to the shadow deque and return the reply it owes
    function automatic deque_reply_t deque_apply(deque_req_t rq);
        deque_reply_t rp;
        int           hit;
        int           i;
        rp.ok     = 1'b0;
        rp.handle = '0;
        case (rq.kind)
            REQ_APPEND: begin
                if (rq.handle != '0 && shadow_fill < DEPTH) begin
                    shadow_slots[4'(shadow_front + shadow_fill)] = rq.handle;
                    shadow_fill++;
                    rp.ok = 1'b1;
                end
            end
            REQ_INSERT: begin
                if (rq.handle != '0 && shadow_fill < DEPTH) begin
                    shadow_front = shadow_front - 4'd1;
                    shadow_slots[shadow_front] = rq.handle;
                    shadow_fill++;
                    rp.ok = 1'b1;
                end
            end
            REQ_TAKE: begin
                if (shadow_fill != '0) begin
                    rp.ok     = 1'b1;
                    rp.handle = shadow_slots[shadow_front];
                    shadow_front = shadow_front + 4'd1;
                    shadow_fill--;
                end
            end
            REQ_READ: begin
                if (rq.pos < shadow_fill) begin
                    rp.ok     = 1'b1;
                    rp.handle = shadow_slots[4'(shadow_front + rq.pos)];
                end
            end
            REQ_REMOVE: begin
                // first match wins, later entries slide one place forward
                hit = -1;
                if (rq.handle != '0) begin
                    for (i = 0; i < shadow_fill; i++) begin
                        if (hit < 0 && shadow_slots[4'(shadow_front + i)] == rq.handle)
                            hit = i;
                    end
                end
                if (hit >= 0) begin
                    for (i = hit; i + 1 < shadow_fill; i++)
                        shadow_slots[4'(shadow_front + i)] =
                            shadow_slots[4'(shadow_front + i + 1)];
                    shadow_fill--;
                    rp.ok = 1'b1;
                end
            end
            default: ;
        endcase
        rp.fill = shadow_fill;
        return rp;
    endfunction

    // mostly short gaps, a few long ones, and zero-gap bursts now and then
    function automatic int gap_len(inout bit burst);
        int r;
        if ($urandom_range(0, 59) == 0)
            burst = ~burst;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // handles drawn mostly from a small pool so removes find their target
    function automatic logic [HANDLE_W-1:0] pick_handle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return '0;
        if (r < 82)
            return handle_pool[$urandom_range(0, POOL_N - 1)];
        return $urandom();
    endfunction

    function automatic deque_req_t random_request(phase_t ph);
        deque_req_t rq;
        int         r;
        r = $urandom_range(0, 99);
        rq.handle = pick_handle();
        rq.pos    = 4'($urandom_range(0, 15));
        rq.kind   = 3'($urandom_range(5, 7));
        case (ph)
            PH_FILL: begin
                if (r < 45)      rq.kind = REQ_APPEND;
                else if (r < 80) rq.kind = REQ_INSERT;
                else if (r < 88) rq.kind = REQ_READ;
                else if (r < 94) rq.kind = REQ_TAKE;
                else if (r < 98) rq.kind = REQ_REMOVE;
            end
            PH_DRAIN: begin
                if (r < 35)      rq.kind = REQ_TAKE;
                else if (r < 70) rq.kind = REQ_REMOVE;
                else if (r < 82) rq.kind = REQ_READ;
                else if (r < 90) rq.kind = REQ_APPEND;
                else if (r < 97) rq.kind = REQ_INSERT;
            end
            default: begin
                if (r < 20)      rq.kind = REQ_APPEND;
                else if (r < 40) rq.kind = REQ_INSERT;
                else if (r < 58) rq.kind = REQ_TAKE;
                else if (r < 76) rq.kind = REQ_READ;
                else if (r < 96) rq.kind = REQ_REMOVE;
            end
        endcase
        return rq;
    endfunction

    function automatic deque_req_t mk_req(logic [2:0] kind, logic [HANDLE_W-1:0] handle,
                                          logic [3:0] pos);
        deque_req_t rq;
        rq.kind   = kind;
        rq.handle = handle;
        rq.pos    = pos;
        return rq;
    endfunction

    task automatic report_mismatch(string what, logic [HANDLE_W-1:0] got,
                                   logic [HANDLE_W-1:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        err_count++;
    endtask

    // request driver, changes inputs on the falling edge
    always @(negedge aclk) begin
        deque_req_t rq;
        if (aresetn && (!s_valid || req_taken)) begin
            if (send_idle > 0) begin
                s_valid   <= 1'b0;
                send_idle <= send_idle - 1;
            end else if (req_q.size() != 0) begin
                rq = req_q.pop_front();
                s_valid      <= 1'b1;
                s_req_type   <= rq.kind;
                s_item_value <= rq.handle;
                s_position   <= rq.pos;
                send_idle    <= gap_len(send_burst);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // reply side back-pressure
    always @(negedge aclk) begin
        if (aresetn) begin
            if (recv_idle > 0) begin
                m_ready   <= 1'b0;
                recv_idle <= recv_idle - 1;
            end else begin
                m_ready   <= 1'b1;
                recv_idle <= gap_len(recv_burst);
            end
        end
    end

    // monitor: check replies, then predict newly accepted requests
    always @(posedge aclk) begin
        deque_reply_t want;
        req_taken <= s_valid && s_ready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (awaited_replies.size() == 0) begin
                    report_mismatch("reply with nothing pending, item_out", m_item_out, '0);
                end else begin
                    want = awaited_replies.pop_front();
                    if (m_ok !== want.ok)
                        report_mismatch("ok", HANDLE_W'(m_ok), HANDLE_W'(want.ok));
                    if (m_item_out !== want.handle)
                        report_mismatch("item_out", m_item_out, want.handle);
                    if (m_fill_count !== want.fill)
                        report_mismatch("fill_count", HANDLE_W'(m_fill_count),
                                        HANDLE_W'(want.fill));
                end
            end
            if (s_valid && s_ready)
                awaited_replies.push_back(deque_apply(mk_req(s_req_type, s_item_value,
                                                             s_position)));
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_MAX) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        phase_t ph;
        int     left;
        int     n;
        for (n = 0; n < POOL_N; n++)
            handle_pool[n] = $urandom() | 32'h1;
        handle_pool[0] = '1;
        handle_pool[1] = 32'h8000_0000;

        // directed: empty store, null handles, extremes, misses, unknown codes
        req_q.push_back(mk_req(REQ_TAKE,   32'h0,         4'd0));
        req_q.push_back(mk_req(REQ_REMOVE, 32'h5,         4'd0));
        req_q.push_back(mk_req(REQ_READ,   32'h0,         4'd0));
        req_q.push_back(mk_req(REQ_APPEND, 32'h0,         4'd0));
        req_q.push_back(mk_req(REQ_INSERT, 32'h0,         4'd0));
        req_q.push_back(mk_req(REQ_APPEND, 32'hFFFF_FFFF, 4'd0));
        req_q.push_back(mk_req(REQ_INSERT, 32'h1,         4'd0));
        req_q.push_back(mk_req(REQ_APPEND, 32'h8000_0000, 4'd0));
        req_q.push_back(mk_req(REQ_READ,   32'h0,         4'd0));
        req_q.push_back(mk_req(REQ_READ,   32'hFFFF_FFFF, 4'd2));
        req_q.push_back(mk_req(REQ_READ,   32'h0,         4'd3));
        req_q.push_back(mk_req(REQ_READ,   32'h0,         4'd15));
        req_q.push_back(mk_req(REQ_REMOVE, 32'hDEAD_BEEF, 4'd0));
        req_q.push_back(mk_req(REQ_REMOVE, 32'h0,         4'd0));
        req_q.push_back(mk_req(3'd5,       32'h1,         4'd1));
        req_q.push_back(mk_req(3'd6,       32'hFFFF_FFFF, 4'd15));
        req_q.push_back(mk_req(3'd7,       32'h8000_0000, 4'd0));
        req_q.push_back(mk_req(REQ_REMOVE, 32'h8000_0000, 4'd0));
        req_q.push_back(mk_req(REQ_REMOVE, 32'h1,         4'd0));
        req_q.push_back(mk_req(REQ_TAKE,   32'h0,         4'd0));
        req_q.push_back(mk_req(REQ_TAKE,   32'h0,         4'd0));

        // random phases that fill, drain and churn the store
        n = 0;
        while (n < NUM_RANDOM) begin
            ph   = phase_t'($urandom_range(0, 2));
            left = $urandom_range(20, 60);
            while (left > 0 && n < NUM_RANDOM) begin
                req_q.push_back(random_request(ph));
                left--;
                n++;
            end
        end

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (req_q.size() != 0 || s_valid || awaited_replies.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
